// ----- hw/rtl/hsvcl_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvcl_pkg
// Shared types and constants of the HSV lighten block.
// ----------------------------------------------------------------------------
package hsvcl_pkg;
    localparam int ChanW  = 8;
    localparam int AmtW   = 9;
    localparam int ModeW  = 2;

    typedef enum logic [ModeW-1:0] {
        MODE_LIGHTEN = 2'd0,
        MODE_TO_HSV  = 2'd1,
        MODE_TO_RGB  = 2'd2,
        MODE_PASS    = 2'd3
    } t_mode;

    typedef enum logic {
        REG_MODE   = 1'b0,
        REG_AMOUNT = 1'b1
    } t_reg_idx;

    localparam logic [ModeW-1:0] ResetMode   = 2'd0;
    localparam logic [AmtW-1:0]  ResetAmount = 9'd243;

    typedef struct packed {
        logic [ChanW-1:0] c0;
        logic [ChanW-1:0] c1;
        logic [ChanW-1:0] c2;
        logic [ChanW-1:0] alpha;
    } t_color;

    // Truncated x/255 for x < 65280, where the quotient fits 8 bits: (x + 1 + (x >> 8)) >> 8 is exact.
    function automatic logic [ChanW-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction
endpackage

// ----- hw/rtl/hsvcl_if.sv -----
// ----------------------------------------------------------------------------
// hsvcl_if
// Valid/ready channels for color items and configuration writes.
// ----------------------------------------------------------------------------
interface hsvcl_color_if;
    logic              valid;
    logic              ready;
    hsvcl_pkg::t_color data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hsvcl_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [8:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- hw/rtl/hsvcl_divu.sv -----
// ----------------------------------------------------------------------------
// hsvcl_divu
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hsvcl_divu #(
    parameter int NumW = 16,
    parameter int DenW = 11,
    parameter int QW   = 8
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [NumW-1:0] i_num,
    input  logic [DenW-1:0] i_den,
    output logic [QW-1:0]   o_quo
);
    // Quotient is known to fit in QW bits; stage k resolves bit QW-1-k.
    logic [NumW-1:0] r_rem [QW+1];
    logic [DenW-1:0] r_den [QW+1];
    logic [QW-1:0]   r_q   [QW+1];

    assign r_rem[0] = i_num;
    assign r_den[0] = i_den;
    assign r_q[0]   = '0;

    for (genvar k = 0; k < QW; k++) begin : g_st
        localparam int Sh = QW - 1 - k;
        logic [NumW+QW-1:0] n_trial;
        logic               n_ge;
        logic [NumW-1:0]    r_rem_s;
        logic [DenW-1:0]    r_den_s;
        logic [QW-1:0]      r_q_s;
        assign n_trial = (NumW+QW)'(r_den[k]) << Sh;
        assign n_ge    = (NumW+QW)'(r_rem[k]) >= n_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_s <= n_ge ? r_rem[k] - n_trial[NumW-1:0] : r_rem[k];
                r_den_s <= r_den[k];
                r_q_s   <= r_q[k] | (QW'(n_ge) << Sh);
            end
        end
        assign r_rem[k+1] = r_rem_s;
        assign r_den[k+1] = r_den_s;
        assign r_q[k+1]   = r_q_s;
    end

    assign o_quo = r_q[QW];
endmodule

// ----- hw/rtl/hsvcl_top_stage.sv -----
// ----------------------------------------------------------------------------
// hsvcl_top_stage
// Delay line for side data that rides beside the pipelined arithmetic.
// ----------------------------------------------------------------------------
module hsvcl_top_stage #(
    parameter int W     = 8,
    parameter int Depth = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [Depth];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < Depth; k++) r_tap[k] <= r_tap[k-1];
        end
    end
    assign o_q = r_tap[Depth-1];
endmodule

// ----- hw/rtl/hsv_color_lighten.sv -----
// ----------------------------------------------------------------------------
// hsv_color_lighten
// RGB/HSV conversion and value lightening, one color item per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                              Accept
// i_pix     in   first/second/third channel, alpha    valid & ready
// o_pix     out  out_first/second/third, alpha        valid & ready
// i_cfg     in   index (0 mode, 1 amount), wdata      valid & ready
//
// Throughput is one item per clock while the output is not stalled. The pipeline is the
// eight-stage pipelined hue and saturation dividers plus the min/max, lighten,
// multiply and constant-divide stages around them and the output registers.
// Reset clears the valid bits and loads the register defaults. A stall on the
// output freezes every stage at once, so nothing is lost or repeated; ready is
// low only while stalled.
// ----------------------------------------------------------------------------
module hsv_color_lighten #(
    parameter logic [1:0] RESET_MODE   = hsvcl_pkg::ResetMode,
    parameter logic [8:0] RESET_AMOUNT = hsvcl_pkg::ResetAmount
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hsvcl_color_if.sink   i_pix,
    hsvcl_color_if.source o_pix,
    hsvcl_cfg_if.sink     i_cfg
);
    localparam int Lat = 20;

    logic [1:0] r_mode;
    logic [8:0] r_amount;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RESET_MODE;
            r_amount <= RESET_AMOUNT;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == 8'(hsvcl_pkg::REG_MODE)) r_mode <= i_cfg.wdata[1:0];
            else if (i_cfg.index == 8'(hsvcl_pkg::REG_AMOUNT)) r_amount <= i_cfg.wdata;
        end
    end

    // Whole pipeline advances when the output is free or taken.
    logic en;
    logic [Lat-1:0] r_vld;
    assign en          = !o_pix.valid || o_pix.ready;
    assign i_pix.ready = en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[Lat-2:0], i_pix.valid};
    end
    assign o_pix.valid = r_vld[Lat-1];

    // ---- Stage 1: max, min, hue sector select.
    logic [7:0] a, b, c;
    assign a = i_pix.data.c0;
    assign b = i_pix.data.c1;
    assign c = i_pix.data.c2;
    logic [7:0] mx, mn, d;
    logic [10:0] hn;  // base*d + num, below 6*d
    always_comb begin
        mx = a; mn = a;
        if (b > mx) mx = b;
        if (c > mx) mx = c;
        if (b < mn) mn = b;
        if (c < mn) mn = c;
        d = mx - mn;
        if (a == mx) hn = (b < c) ? 11'(6 * d) + 11'(b) - 11'(c) : 11'(b) - 11'(c);
        else if (b == mx) hn = 11'(2 * d) + 11'(c) - 11'(a);
        else hn = 11'(4 * d) + 11'(a) - 11'(b);
    end
    logic [7:0]  r1_mx, r1_d;
    logic [10:0] r1_hn;
    logic [1:0]  r1_mode;
    logic [8:0]  r1_amt;
    logic [31:0] r1_pass;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mx <= mx; r1_d <= d; r1_hn <= hn;
            r1_mode <= r_mode; r1_amt <= r_amount;
            r1_pass <= i_pix.data;
        end
    end

    // ---- Stages 2..9: hue and saturation divides in parallel.
    logic [7:0] h_q, s_q;
    hsvcl_divu #(.NumW(19), .DenW(11), .QW(8)) u_hdiv (
        .i_clk(i_clk), .i_en(en), .i_num({r1_hn, 8'd0}),
        .i_den(11'(6 * r1_d)), .o_quo(h_q));
    hsvcl_divu #(.NumW(16), .DenW(8), .QW(8)) u_sdiv (
        .i_clk(i_clk), .i_en(en), .i_num(16'(r1_d) * 16'd255),
        .i_den(r1_mx == 8'd0 ? 8'd1 : r1_mx), .o_quo(s_q));
    logic [7:0]  s9_mx, s9_d;
    logic [1:0]  s9_mode;
    logic [8:0]  s9_amt;
    logic [31:0] s9_pass;
    hsvcl_top_stage #(.W(59), .Depth(8)) u_d1 (
        .i_clk(i_clk), .i_en(en),
        .i_d({r1_mx, r1_d, r1_mode, r1_amt, r1_pass}),
        .o_q({s9_mx, s9_d, s9_mode, s9_amt, s9_pass}));

    // ---- Stage 10: choose HSV source, lighten product.
    logic [7:0] h10, s10, v10;
    always_comb begin
        h10 = (s9_d == 8'd0) ? 8'd0 : h_q;
        s10 = (s9_mx == 8'd0) ? 8'd0 : s_q;
        v10 = s9_mx;
    end
    logic [7:0]  r10_h, r10_s, r10_v;
    logic [16:0] r10_lp;
    logic [1:0]  r10_mode;
    logic [31:0] r10_pass;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_h <= h10; r10_s <= s10; r10_v <= v10;
            r10_lp <= 17'(8'd255 - v10) * 17'(s9_amt);
            r10_mode <= s9_mode; r10_pass <= s9_pass;
        end
    end

    // ---- Stage 11: saturating value add; pick HSV->RGB inputs.
    logic [9:0]  vl;
    logic [7:0]  hh, ss, vv;
    assign vl = 10'(r10_v) + 10'(r10_lp[16:8]);
    always_comb begin
        if (r10_mode == hsvcl_pkg::MODE_LIGHTEN) begin
            hh = r10_h; ss = r10_s; vv = (vl > 10'd255) ? 8'd255 : vl[7:0];
        end else begin
            hh = r10_pass[31:24]; ss = r10_pass[23:16]; vv = r10_pass[15:8];
        end
    end
    logic [7:0]  r11_s, r11_v, r11_f;
    logic [2:0]  r11_i;
    logic [1:0]  r11_mode;
    logic [31:0] r11_pass;
    logic [7:0]  r11_h, r11_sh, r11_vh;
    logic [10:0] h6;
    assign h6 = 11'(hh) * 11'd6;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_s <= ss; r11_v <= vv; r11_f <= h6[7:0]; r11_i <= h6[10:8];
            r11_mode <= r10_mode; r11_pass <= r10_pass;
            r11_h <= r10_h; r11_sh <= r10_s; r11_vh <= r10_v;
        end
    end

    // ---- Stage 12: factor products.
    logic [15:0] r12_fs, r12_gs;
    logic [7:0]  r12_v, r12_ps;
    logic [2:0]  r12_i;
    logic [1:0]  r12_mode;
    logic [31:0] r12_pass;
    logic [23:0] r12_hsv;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_fs <= 16'(r11_f) * 16'(r11_s);
            r12_gs <= (16'd256 - 16'(r11_f)) * 16'(r11_s);
            r12_ps <= 8'd255 - r11_s;
            r12_v <= r11_v; r12_i <= r11_i;
            r12_mode <= r11_mode; r12_pass <= r11_pass;
            r12_hsv <= {r11_h, r11_sh, r11_vh};
        end
    end

    // ---- Stage 13: numerators.
    logic [23:0] r13_qn, r13_tn;
    logic [15:0] r13_pn;
    logic [7:0]  r13_v;
    logic [2:0]  r13_i;
    logic [1:0]  r13_mode;
    logic [31:0] r13_pass;
    logic [23:0] r13_hsv;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r13_qn <= 24'(r12_v) * (24'd65280 - 24'(r12_fs));
            r13_tn <= 24'(r12_v) * (24'd65280 - 24'(r12_gs));
            r13_pn <= 16'(r12_v) * 16'(r12_ps);
            r13_v <= r12_v; r13_i <= r12_i;
            r13_mode <= r12_mode; r13_pass <= r12_pass; r13_hsv <= r12_hsv;
        end
    end

    // ---- Stage 14: p, q and t quotients. Since 65280 is 255 * 256, a
    // truncated divide by 65280 is a right shift by 8 and then a truncated
    // divide by 255.
    logic [7:0]  s14_p, s14_q, s14_t, s14_v;
    logic [2:0]  s14_i;
    logic [1:0]  s14_mode;
    logic [31:0] s14_pass;
    logic [23:0] s14_hsv;
    hsvcl_top_stage #(.W(93), .Depth(1)) u_d2 (
        .i_clk(i_clk), .i_en(en),
        .i_d({hsvcl_pkg::div255(r13_pn), hsvcl_pkg::div255(r13_qn[23:8]),
              hsvcl_pkg::div255(r13_tn[23:8]), r13_v, r13_i, r13_mode,
              r13_pass, r13_hsv}),
        .o_q({s14_p, s14_q, s14_t, s14_v, s14_i, s14_mode, s14_pass, s14_hsv}));

    // ---- Sector mux and mode select, feeding the output registers.
    logic [23:0] rgb;
    logic [31:0] res;
    always_comb begin
        case (s14_i)
            3'd0:    rgb = {s14_v, s14_t, s14_p};
            3'd1:    rgb = {s14_q, s14_v, s14_p};
            3'd2:    rgb = {s14_p, s14_v, s14_t};
            3'd3:    rgb = {s14_p, s14_q, s14_v};
            3'd4:    rgb = {s14_t, s14_p, s14_v};
            default: rgb = {s14_v, s14_p, s14_q};
        endcase
        case (s14_mode)
            hsvcl_pkg::MODE_LIGHTEN,
            hsvcl_pkg::MODE_TO_RGB:  res = {rgb, s14_pass[7:0]};
            hsvcl_pkg::MODE_TO_HSV:  res = {s14_hsv, s14_pass[7:0]};
            default:                 res = s14_pass;
        endcase
    end

    // ---- Stages 15..20: output alignment registers.
    hsvcl_top_stage #(.W(32), .Depth(Lat-14)) u_out (
        .i_clk(i_clk), .i_en(en), .i_d(res), .o_q(o_pix.data));

`ifndef SYNTHESIS
    a_ready_follows_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |-> !i_pix.ready)
        else $error("input accepted while output stalled");
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |=> o_pix.valid)
        else $error("stalled item dropped");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !r_vld[Lat-2]) |=> !o_pix.valid)
        else $error("item invented at output");
`endif
endmodule
